### rtl/core/dtpy_pkg.sv
package dtpy_pkg;

   localparam int CORDIC_STEPS_DEF = 24;
   localparam int CORDIC_STEPS_MIN = 12;
   localparam int CORDIC_STEPS_MAX = 32;

   localparam int IN_W    = 32;
   localparam int DIFF_W  = 33;
   localparam int VEC_W   = 48;
   localparam int ANG_W   = 64;
   localparam int SHIFT_W = 6;
   localparam int MB_W    = 35;
   localparam int PROD_W  = 61;
   localparam int PITCH_W = 24;
   localparam int YAW_W   = 26;

   localparam logic [63:0] PI4_Q60 = 64'h0C90FDAA22168C23;
   localparam logic [30:0] GAIN_Q30 = 31'd1768195363;
   localparam logic [29:0] RAD2DEG_Q24 = 30'd961263669;
   localparam logic signed [PITCH_W-1:0] DEG90_Q16 = 24'sd5898240;
   localparam logic signed [YAW_W-1:0] DEG180_Q16 = 26'sd11796480;

   // Angle flags that ride along with the vectors through both rotator chains.
   typedef struct packed {
      logic no_dir;
      logic dy_zero;
      logic dx_zero;
      logic dx_nonneg;
      logic dy_pos;
      logic dz_zero;
      logic dz_neg;
   } flags_type;

   // atan(2^-idx) in radians with 60 fraction bits, truncated series.
   function automatic logic [63:0] atan_q60(input int idx);
      logic [63:0] sum;
      logic [63:0] term;
      int e;
      sum = 64'd0;
      if (idx == 0) begin
         sum = PI4_Q60;
      end else begin
         for (int k = 0; k < 64; k++) begin
            e = 60 - idx * (2 * k + 1);
            if (e >= 0) begin
               term = (64'd1 << e) / 64'(2 * k + 1);
               if ((k % 2) == 1) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
            end
         end
      end
      return sum;
   endfunction

endpackage

### rtl/core/dtpy_cordic_cell.sv
module dtpy_cordic_cell #(
   parameter int Idx  = 0,
   parameter int TagW = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [dtpy_pkg::VEC_W-1:0]    in_x,
   input  logic signed [dtpy_pkg::VEC_W-1:0]    in_y,
   input  logic signed [dtpy_pkg::ANG_W-1:0]    in_z,
   input  logic [TagW-1:0]                      in_tag,
   output logic                                 out_valid,
   output logic signed [dtpy_pkg::VEC_W-1:0]    out_x,
   output logic signed [dtpy_pkg::VEC_W-1:0]    out_y,
   output logic signed [dtpy_pkg::ANG_W-1:0]    out_z,
   output logic [TagW-1:0]                      out_tag
);

   localparam logic [dtpy_pkg::ANG_W-1:0] AngU = dtpy_pkg::atan_q60(Idx);

   logic                                valid_ff;
   logic signed [dtpy_pkg::VEC_W-1:0]   x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [dtpy_pkg::ANG_W-1:0]   z_ff, z_in;
   logic [TagW-1:0]                     tag_ff;

   // One micro-rotation: turn the vector toward the x axis.
   always_comb begin
      xs = in_x >>> Idx;
      ys = in_y >>> Idx;
      if (!in_y[dtpy_pkg::VEC_W-1]) begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + signed'(AngU);
      end else begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - signed'(AngU);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      tag_ff <= in_tag;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_tag   = tag_ff;

endmodule

### rtl/core/dtpy_to_deg.sv
module dtpy_to_deg (
   input  logic                                 clock,
   input  logic signed [dtpy_pkg::ANG_W-1:0]    angle,
   output logic signed [dtpy_pkg::PITCH_W-1:0]  degrees
);

   logic [dtpy_pkg::ANG_W-1:0]          mag;
   logic [33:0]                         q_ff, q_in;
   logic                                neg_ff;
   logic [63:0]                         prod;
   logic [23:0]                         d;
   logic signed [dtpy_pkg::PITCH_W-1:0] deg_ff, deg_in;

   // Round the magnitude to 32 fraction bits, then scale by 180/pi.
   always_comb begin
      mag  = angle[dtpy_pkg::ANG_W-1] ? 64'(-angle) : 64'(angle);
      q_in = 34'((mag + 64'd134217728) >> 28);
   end

   always_comb begin
      prod = 64'(q_ff) * 64'(dtpy_pkg::RAD2DEG_Q24);
      d    = 24'((prod + 64'd549755813888) >> 40);
      if (d > 24'(dtpy_pkg::DEG90_Q16)) begin
         d = 24'(dtpy_pkg::DEG90_Q16);
      end
      deg_in = neg_ff ? -signed'(d) : signed'(d);
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      neg_ff <= angle[dtpy_pkg::ANG_W-1];
      deg_ff <= deg_in;
   end

   assign degrees = deg_ff;

endmodule

### rtl/core/direction_to_pitch_yaw.sv
// Throughput: one transaction per clock cycle; busy stays low, start may be held high.
// Each stage of the two rotator chains is one cell, so CordicSteps sets the chain depth.
// Reset is synchronous and active high; it clears all valid bits, data regs keep garbage.
// The receiver cannot stall: every result is shown for exactly one cycle with rsp_valid.
module direction_to_pitch_yaw #(
   parameter int CordicSteps = dtpy_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [dtpy_pkg::IN_W-1:0]     req_src_x,
   input  logic signed [dtpy_pkg::IN_W-1:0]     req_src_y,
   input  logic signed [dtpy_pkg::IN_W-1:0]     req_src_z,
   input  logic signed [dtpy_pkg::IN_W-1:0]     req_dst_x,
   input  logic signed [dtpy_pkg::IN_W-1:0]     req_dst_y,
   input  logic signed [dtpy_pkg::IN_W-1:0]     req_dst_z,
   output logic                                 rsp_valid,
   output logic signed [dtpy_pkg::PITCH_W-1:0]  rsp_pitch_deg,
   output logic signed [dtpy_pkg::YAW_W-1:0]    rsp_yaw_deg,
   output logic                                 rsp_no_direction
);

   localparam int VW = dtpy_pkg::VEC_W;
   localparam int AW = dtpy_pkg::ANG_W;
   localparam int FW = $bits(dtpy_pkg::flags_type);
   // The yaw chain carries the shift, the scaled |dz| and the flags.
   localparam int YTagW = dtpy_pkg::SHIFT_W + dtpy_pkg::MB_W + FW;
   // The pitch chain carries the finished yaw angle and the flags.
   localparam int PTagW = AW + FW;

   // The pipeline never holds a transaction off.
   assign busy = 1'b0;

   // Stage 0: exact 33-bit differences.
   logic                                 v0_ff;
   logic signed [dtpy_pkg::DIFF_W-1:0]   dx_ff, dy_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start;
      end
      dx_ff <= 33'(req_src_x) - 33'(req_dst_x);
      dy_ff <= 33'(req_src_y) - 33'(req_dst_y);
      dz_ff <= 33'(req_src_z) - 33'(req_dst_z);
   end

   // Stage 1: normalize the horizontal vector so its larger component has bit 39 set,
   // and start the gain multiply on the low bits of |dz|.
   logic [dtpy_pkg::DIFF_W-1:0]         mx, my, mz, m;
   logic [5:0]                          bitlen;
   logic [dtpy_pkg::SHIFT_W-1:0]        s1_ff, s1_in;
   logic signed [VW-1:0]                x0_ff, x0_in, y0_ff, y0_in, y0mag;
   logic [2:0]                          mz_hi_ff;
   logic [dtpy_pkg::PROD_W-1:0]         prod_lo_ff, prod_lo_in;
   dtpy_pkg::flags_type                 flags1_ff, flags1_in;
   logic                                v1_ff;

   always_comb begin
      mx = dx_ff[dtpy_pkg::DIFF_W-1] ? 33'(-dx_ff) : 33'(dx_ff);
      my = dy_ff[dtpy_pkg::DIFF_W-1] ? 33'(-dy_ff) : 33'(dy_ff);
      mz = dz_ff[dtpy_pkg::DIFF_W-1] ? 33'(-dz_ff) : 33'(dz_ff);
      m  = (mx > my) ? mx : my;
      bitlen = 6'd0;
      for (int i = 0; i < dtpy_pkg::DIFF_W; i++) begin
         if (m[i]) begin
            bitlen = 6'(i + 1);
         end
      end
      s1_in = 6'(6'd40 - bitlen);
      x0_in = 48'(mx) << s1_in;
      y0mag = 48'(my) << s1_in;
      y0_in = (dx_ff[dtpy_pkg::DIFF_W-1] != dy_ff[dtpy_pkg::DIFF_W-1]) ? -y0mag : y0mag;
      prod_lo_in = 61'(mz[29:0]) * 61'(dtpy_pkg::GAIN_Q30);
      flags1_in.dx_zero   = (dx_ff == '0);
      flags1_in.dy_zero   = (dy_ff == '0);
      flags1_in.no_dir    = (dx_ff == '0) && (dy_ff == '0);
      flags1_in.dx_nonneg = !dx_ff[dtpy_pkg::DIFF_W-1];
      flags1_in.dy_pos    = !dy_ff[dtpy_pkg::DIFF_W-1] && (dy_ff != '0);
      flags1_in.dz_zero   = (dz_ff == '0);
      flags1_in.dz_neg    = dz_ff[dtpy_pkg::DIFF_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      s1_ff      <= s1_in;
      x0_ff      <= x0_in;
      y0_ff      <= y0_in;
      mz_hi_ff   <= mz[32:30];
      prod_lo_ff <= prod_lo_in;
      flags1_ff  <= flags1_in;
   end

   // Stage 2: finish the gain-scaled |dz| (rounded on the low part).
   logic                                v2_ff;
   logic signed [VW-1:0]                x2_ff, y2_ff;
   logic [dtpy_pkg::MB_W-1:0]           mb_ff, mb_in;
   logic [dtpy_pkg::SHIFT_W-1:0]        s2_ff;
   dtpy_pkg::flags_type                 flags2_ff;

   always_comb begin
      mb_in = 35'(35'(mz_hi_ff) * 35'(dtpy_pkg::GAIN_Q30))
            + 35'((prod_lo_ff + 61'd536870912) >> 30);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      x2_ff     <= x0_ff;
      y2_ff     <= y0_ff;
      mb_ff     <= mb_in;
      s2_ff     <= s1_ff;
      flags2_ff <= flags1_ff;
   end

   // Yaw rotator chain.
   logic                 yv   [0:CordicSteps];
   logic signed [VW-1:0] yx   [0:CordicSteps];
   logic signed [VW-1:0] yy   [0:CordicSteps];
   logic signed [AW-1:0] yz   [0:CordicSteps];
   logic [YTagW-1:0]     ytag [0:CordicSteps];

   assign yv[0]   = v2_ff;
   assign yx[0]   = x2_ff;
   assign yy[0]   = y2_ff;
   assign yz[0]   = '0;
   assign ytag[0] = {s2_ff, mb_ff, flags2_ff};

   for (genvar i = 0; i < CordicSteps; i++) begin : g_yaw
      dtpy_cordic_cell #(.Idx(i), .TagW(YTagW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (yv[i]),
         .in_x      (yx[i]),
         .in_y      (yy[i]),
         .in_z      (yz[i]),
         .in_tag    (ytag[i]),
         .out_valid (yv[i+1]),
         .out_x     (yx[i+1]),
         .out_y     (yy[i+1]),
         .out_z     (yz[i+1]),
         .out_tag   (ytag[i+1])
      );
   end

   // Stage 3: build the pitch vector from the yaw chain's hypot and the scaled dz.
   logic [dtpy_pkg::SHIFT_W-1:0]        s3;
   logic [dtpy_pkg::MB_W-1:0]           mb3;
   dtpy_pkg::flags_type                 flags3;
   logic [5:0]                          mb_len;
   logic [dtpy_pkg::SHIFT_W-1:0]        tmax, t;
   logic signed [VW-1:0]                a_in, a_ff, b_in, b_ff, bmag;
   logic signed [AW-1:0]                yawz_ff;
   dtpy_pkg::flags_type                 flags4_ff;
   logic                                v3_ff;

   always_comb begin
      {s3, mb3, flags3} = ytag[CordicSteps];
      mb_len = 6'd0;
      for (int i = 0; i < dtpy_pkg::MB_W; i++) begin
         if (mb3[i]) begin
            mb_len = 6'(i + 1);
         end
      end
      tmax = 6'(6'd41 - mb_len);
      t    = (tmax < s3) ? tmax : s3;
      a_in = yx[CordicSteps] >>> (s3 - t);
      bmag = 48'(mb3) << t;
      b_in = flags3.dz_neg ? -bmag : bmag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= yv[CordicSteps];
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      yawz_ff   <= yz[CordicSteps];
      flags4_ff <= flags3;
   end

   // Pitch rotator chain.
   logic                 pv   [0:CordicSteps];
   logic signed [VW-1:0] px   [0:CordicSteps];
   logic signed [VW-1:0] py   [0:CordicSteps];
   logic signed [AW-1:0] pz   [0:CordicSteps];
   logic [PTagW-1:0]     ptag [0:CordicSteps];

   assign pv[0]   = v3_ff;
   assign px[0]   = a_ff;
   assign py[0]   = b_ff;
   assign pz[0]   = '0;
   assign ptag[0] = {yawz_ff, flags4_ff};

   for (genvar i = 0; i < CordicSteps; i++) begin : g_pitch
      dtpy_cordic_cell #(.Idx(i), .TagW(PTagW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (pv[i]),
         .in_x      (px[i]),
         .in_y      (py[i]),
         .in_z      (pz[i]),
         .in_tag    (ptag[i]),
         .out_valid (pv[i+1]),
         .out_x     (px[i+1]),
         .out_y     (py[i+1]),
         .out_z     (pz[i+1]),
         .out_tag   (ptag[i+1])
      );
   end

   // Radian to degree conversion of both angles, two stages each.
   logic signed [AW-1:0]                yaw_z_end;
   dtpy_pkg::flags_type                 flags_end;
   logic signed [dtpy_pkg::PITCH_W-1:0] pitch_deg, yaw_deg;

   assign {yaw_z_end, flags_end} = ptag[CordicSteps];

   dtpy_to_deg u_pitch_deg (
      .clock   (clock),
      .angle   (pz[CordicSteps]),
      .degrees (pitch_deg)
   );

   dtpy_to_deg u_yaw_deg (
      .clock   (clock),
      .angle   (yaw_z_end),
      .degrees (yaw_deg)
   );

   // Flags and valid are delayed to line up with the converters.
   logic                v5_ff, v6_ff;
   dtpy_pkg::flags_type flags5_ff, flags6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v5_ff <= pv[CordicSteps];
         v6_ff <= v5_ff;
      end
      flags5_ff <= flags_end;
      flags6_ff <= flags5_ff;
   end

   // Output stage: special cases for axis-aligned and vertical vectors, then the
   // 180 degree offset for a nonnegative dx.
   logic                                out_valid_ff;
   logic signed [dtpy_pkg::PITCH_W-1:0] pitch_ff, pitch_in;
   logic signed [dtpy_pkg::YAW_W-1:0]   yaw_ff, yaw_in, yaw_base;
   logic                                nodir_ff;

   always_comb begin
      if (flags6_ff.dy_zero) begin
         yaw_base = '0;
      end else if (flags6_ff.dx_zero) begin
         yaw_base = flags6_ff.dy_pos ? 26'(dtpy_pkg::DEG90_Q16) : -26'(dtpy_pkg::DEG90_Q16);
      end else begin
         yaw_base = 26'(yaw_deg);
      end
      if (flags6_ff.no_dir) begin
         yaw_in = '0;
         if (flags6_ff.dz_zero) begin
            pitch_in = '0;
         end else if (flags6_ff.dz_neg) begin
            pitch_in = -dtpy_pkg::DEG90_Q16;
         end else begin
            pitch_in = dtpy_pkg::DEG90_Q16;
         end
      end else begin
         yaw_in   = flags6_ff.dx_nonneg ? yaw_base + dtpy_pkg::DEG180_Q16 : yaw_base;
         pitch_in = flags6_ff.dz_zero ? '0 : pitch_deg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= v6_ff;
      end
      pitch_ff <= pitch_in;
      yaw_ff   <= yaw_in;
      nodir_ff <= flags6_ff.no_dir;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pitch_deg    = pitch_ff;
   assign rsp_yaw_deg      = yaw_ff;
   assign rsp_no_direction = nodir_ff;

endmodule

### rtl/core/dtpy_checker.sv
module dtpy_checker #(
   parameter int CordicSteps = dtpy_pkg::CORDIC_STEPS_DEF
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_valid,
   input logic signed [dtpy_pkg::PITCH_W-1:0]  rsp_pitch_deg,
   input logic signed [dtpy_pkg::YAW_W-1:0]    rsp_yaw_deg,
   input logic                                 rsp_no_direction
);

   localparam int Latency = 2 * CordicSteps + 7;

   // Every result traces back to a start sampled at the Latency offset.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, Latency))
      else $error("result without matching transaction");

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_pitch_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_deg <= dtpy_pkg::DEG90_Q16)
                 && (rsp_pitch_deg >= -dtpy_pkg::DEG90_Q16))
      else $error("pitch out of range");

   a_yaw_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_yaw_deg >= -26'(dtpy_pkg::DEG90_Q16))
                 && (rsp_yaw_deg <= 26'sd17694720))
      else $error("yaw out of range");

   a_nodir_yaw : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_direction) |-> (rsp_yaw_deg == '0))
      else $error("yaw nonzero without horizontal direction");

endmodule

bind direction_to_pitch_yaw dtpy_checker #(.CordicSteps(CordicSteps)) u_dtpy_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_pitch_deg    (rsp_pitch_deg),
   .rsp_yaw_deg      (rsp_yaw_deg),
   .rsp_no_direction (rsp_no_direction)
);

### test/tb_direction_to_pitch_yaw.sv
module tb_direction_to_pitch_yaw;

   localparam int Steps       = dtpy_pkg::CORDIC_STEPS_DEF;
   localparam int Latency     = 2 * Steps + 7;
   localparam int CycleLimit  = 400000;
   localparam int RandomItems = 1030;
   localparam int QuietItems  = 150;

   // One expected angle pair, as the block should present it.
   typedef struct {
      logic signed [dtpy_pkg::PITCH_W-1:0] pitch;
      logic signed [dtpy_pkg::YAW_W-1:0]   yaw;
      logic                                no_dir;
   } angles_type;

   // One row of the directed table. When typed is set, the row carries its own
   // expected result instead of asking the predictor.
   typedef struct {
      logic signed [dtpy_pkg::IN_W-1:0] sx, sy, sz, dx, dy, dz;
      bit                               typed;
      angles_type                       want;
   } point_pair_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic signed [dtpy_pkg::IN_W-1:0]    req_src_x = '0, req_src_y = '0, req_src_z = '0;
   logic signed [dtpy_pkg::IN_W-1:0]    req_dst_x = '0, req_dst_y = '0, req_dst_z = '0;
   logic                                rsp_valid;
   logic signed [dtpy_pkg::PITCH_W-1:0] rsp_pitch_deg;
   logic signed [dtpy_pkg::YAW_W-1:0]   rsp_yaw_deg;
   logic                                rsp_no_direction;

   // Typed expectation for the transaction currently on the request ports.
   bit                        drive_typed = 1'b0;
   angles_type                drive_want;

   angles_type                pending_angles[$];
   bit [63:0]                 arc_q60[32];
   int                        error_count = 0;
   int                        cycle_count = 0;

   always #10 clock = ~clock;

   direction_to_pitch_yaw u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_src_x        (req_src_x),
      .req_src_y        (req_src_y),
      .req_src_z        (req_src_z),
      .req_dst_x        (req_dst_x),
      .req_dst_y        (req_dst_y),
      .req_dst_z        (req_dst_z),
      .rsp_valid        (rsp_valid),
      .rsp_pitch_deg    (rsp_pitch_deg),
      .rsp_yaw_deg      (rsp_yaw_deg),
      .rsp_no_direction (rsp_no_direction)
   );

   // The arctangent table holds atan(2^-i) in Q60 radians. Entry zero is pi/4;
   // the others come from the truncated power series, term by term.
   function automatic void fill_arc_table();
      bit [63:0] sum;
      int        e;
      arc_q60[0] = dtpy_pkg::PI4_Q60;
      for (int i = 1; i < 32; i++) begin
         sum = 64'd0;
         for (int k = 0; k < 64; k++) begin
            e = 60 - i * (2 * k + 1);
            if (e >= 0) begin
               if (k % 2 == 1) begin
                  sum = sum - ((64'd1 << e) / 64'(2 * k + 1));
               end else begin
                  sum = sum + ((64'd1 << e) / 64'(2 * k + 1));
               end
            end
         end
         arc_q60[i] = sum;
      end
   endfunction

   // Vectoring rotation: drives y toward zero and returns the angle swept, in
   // Q60 radians. On return x holds the gain-scaled length of the vector.
   function automatic longint vector_angle(inout longint x, inout longint y);
      longint z;
      longint xs;
      longint ys;
      z = 0;
      for (int i = 0; i < Steps && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(arc_q60[i]);
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(arc_q60[i]);
         end
      end
      return z;
   endfunction

   // Q60 radians to Q16 degrees: round the magnitude to Q32, scale by 180/pi
   // in Q24, round to Q16, restore the sign, and clamp to +/-90 degrees.
   function automatic longint degrees_q16(longint z);
      bit [63:0] m;
      bit [63:0] q;
      longint    r;
      m = (z < 0) ? 64'(-z) : 64'(z);
      q = (m + (64'd1 << 27)) >> 28;
      r = longint'((q * 64'd961263669 + (64'd1 << 39)) >> 40);
      if (z < 0) begin
         r = -r;
      end
      if (r > 5898240) begin
         r = 5898240;
      end
      if (r < -5898240) begin
         r = -5898240;
      end
      return r;
   endfunction

   // Pitch and yaw of the vector from the destination to the source point.
   function automatic angles_type predict_angles(longint sx, longint sy, longint sz,
                                                 longint tx, longint ty, longint tz);
      angles_type res;
      longint     ddx, ddy, ddz, pitch, yaw, x, y, ang, a, b;
      bit [63:0]  mx, my, m, mz, mb;
      int         s1, t;
      ddx = sx - tx;
      ddy = sy - ty;
      ddz = sz - tz;
      res.no_dir = 1'b0;
      if (ddx == 0 && ddy == 0) begin
         // Straight up or down: yaw has no meaning and is reported as zero.
         res.no_dir = 1'b1;
         yaw = 0;
         pitch = (ddz > 0) ? 5898240 : ((ddz < 0) ? -5898240 : 0);
      end else begin
         mx = (ddx < 0) ? 64'(-ddx) : 64'(ddx);
         my = (ddy < 0) ? 64'(-ddy) : 64'(ddy);
         m = (mx > my) ? mx : my;
         // Normalize so that the larger component lies in [2^39, 2^40).
         s1 = 0;
         while ((m << s1) < (64'd1 << 39)) begin
            s1++;
         end
         x = longint'(mx << s1);
         y = longint'(my << s1);
         if ((ddx < 0) != (ddy < 0)) begin
            y = -y;
         end
         ang = vector_angle(x, y);
         if (ddy == 0) begin
            yaw = 0;
         end else if (ddx == 0) begin
            yaw = (ddy > 0) ? 5898240 : -5898240;
         end else begin
            yaw = degrees_q16(ang);
         end
         if (ddx >= 0) begin
            yaw = yaw + 11796480;
         end
         if (ddz == 0) begin
            pitch = 0;
         end else begin
            // The vertical leg is scaled by the rotator gain so that it matches
            // the gain-scaled horizontal length left in x.
            mz = (ddz < 0) ? 64'(-ddz) : 64'(ddz);
            mb = (mz >> 30) * 64'd1768195363 +
                 (((mz & 64'h3FFF_FFFF) * 64'd1768195363 + (64'd1 << 29)) >> 30);
            t = 0;
            while (t < s1 && (mb << (t + 1)) < (64'd1 << 41)) begin
               t++;
            end
            a = x >>> (s1 - t);
            b = longint'(mb << t);
            if (ddz < 0) begin
               b = -b;
            end
            pitch = degrees_q16(vector_angle(a, b));
         end
      end
      res.pitch = pitch[dtpy_pkg::PITCH_W-1:0];
      res.yaw = yaw[dtpy_pkg::YAW_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got,
               want);
      error_count++;
   endtask

   // Scoreboard. Inputs move on the falling edge, so at the rising edge both the
   // accepted request and any result strobe are stable and can be sampled here.
   always @(posedge clock) begin
      angles_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && start && !busy) begin
         if (drive_typed) begin
            pending_angles.push_back(drive_want);
         end else begin
            pending_angles.push_back(predict_angles(req_src_x, req_src_y, req_src_z,
                                                    req_dst_x, req_dst_y, req_dst_z));
         end
      end
      if (!reset && rsp_valid) begin
         if (pending_angles.size() == 0) begin
            report_mismatch("unexpected result, pitch", rsp_pitch_deg, 0);
         end else begin
            want = pending_angles.pop_front();
            if (rsp_pitch_deg !== want.pitch) begin
               report_mismatch("pitch_deg", rsp_pitch_deg, want.pitch);
            end
            if (rsp_yaw_deg !== want.yaw) begin
               report_mismatch("yaw_deg", rsp_yaw_deg, want.yaw);
            end
            if (rsp_no_direction !== want.no_dir) begin
               report_mismatch("no_direction", rsp_no_direction, want.no_dir);
            end
         end
      end
   end

   // A stuck pipeline must not hang the run.
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("tb_direction_to_pitch_yaw: errors");
         $finish;
      end
   end

   // Present one point pair on the falling edge and hold it until accepted.
   // A random pause afterwards, when requested, drops start for the gap.
   task automatic send_pair(input point_pair_type p, input bit allow_gap);
      int gap;
      @(negedge clock);
      start <= 1'b1;
      req_src_x <= p.sx;
      req_src_y <= p.sy;
      req_src_z <= p.sz;
      req_dst_x <= p.dx;
      req_dst_y <= p.dy;
      req_dst_z <= p.dz;
      drive_typed <= p.typed;
      drive_want <= p.want;
      do begin
         @(posedge clock);
      end while (busy);
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic angles_type typed_angles(int pitch, int yaw, bit no_dir);
      angles_type a;
      a.pitch = pitch[dtpy_pkg::PITCH_W-1:0];
      a.yaw = yaw[dtpy_pkg::YAW_W-1:0];
      a.no_dir = no_dir;
      return a;
   endfunction

   function automatic point_pair_type pair_of(int sx, int sy, int sz, int dx, int dy, int dz);
      point_pair_type p;
      p.sx = sx;
      p.sy = sy;
      p.sz = sz;
      p.dx = dx;
      p.dy = dy;
      p.dz = dz;
      p.typed = 1'b0;
      p.want = typed_angles(0, 0, 1'b0);
      return p;
   endfunction

   // Random component. Mostly nearby points so the angles spread over the whole
   // circle; sometimes full-range words, sometimes a zeroed axis.
   function automatic int random_offset(int base);
      case ($urandom_range(0, 5))
         0:       return base;
         1:       return base + $signed($urandom_range(0, 2)) - 1;
         2:       return $urandom();
         3:       return base + $signed($urandom_range(0, 2000)) - 1000;
         default: return base + $signed($urandom()) / (1 << $urandom_range(0, 24));
      endcase
   endfunction

   localparam int MaxI = 32'h7FFF_FFFF;
   localparam int MinI = 32'h8000_0000;

   initial begin
      point_pair_type directed[$];
      point_pair_type p;
      int             n;

      fill_arc_table();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed table. Rows whose answer is plain carry it typed in.
      p = pair_of(0, 0, 0, 0, 0, 0);
      p.typed = 1'b1; p.want = typed_angles(0, 0, 1'b1);                directed.push_back(p);
      p = pair_of(5, 7, 100, 5, 7, 0);
      p.typed = 1'b1; p.want = typed_angles(5898240, 0, 1'b1);          directed.push_back(p);
      p = pair_of(5, 7, MinI, 5, 7, MaxI);
      p.typed = 1'b1; p.want = typed_angles(-5898240, 0, 1'b1);         directed.push_back(p);
      // Zero dy with dz zero: yaw is exactly 180 or 0, pitch exactly 0.
      p = pair_of(300, 4, 9, 1, 4, 9);
      p.typed = 1'b1; p.want = typed_angles(0, 11796480, 1'b0);         directed.push_back(p);
      p = pair_of(MinI, 4, 9, MaxI, 4, 9);
      p.typed = 1'b1; p.want = typed_angles(0, 0, 1'b0);                directed.push_back(p);
      // Zero dx with dy nonzero: yaw is exactly 270 or 90.
      p = pair_of(3, MaxI, 0, 3, MinI, 0);
      p.typed = 1'b1; p.want = typed_angles(0, 17694720, 1'b0);         directed.push_back(p);
      p = pair_of(3, -1, 0, 3, 0, 0);
      p.typed = 1'b1; p.want = typed_angles(0, 5898240, 1'b0);          directed.push_back(p);
      // Extremes and diagonals go through the predictor.
      directed.push_back(pair_of(MaxI, MaxI, MaxI, MinI, MinI, MinI));
      directed.push_back(pair_of(MinI, MinI, MinI, MaxI, MaxI, MaxI));
      directed.push_back(pair_of(MaxI, MinI, MaxI, MinI, MaxI, MinI));
      directed.push_back(pair_of(1, 0, MaxI, 0, 0, MinI));
      directed.push_back(pair_of(0, 1, MinI, 0, 0, MaxI));
      directed.push_back(pair_of(1, 1, 1, 0, 0, 0));
      directed.push_back(pair_of(-1, 1, -1, 0, 0, 0));
      directed.push_back(pair_of(-1, -1, 1, 0, 0, 0));
      directed.push_back(pair_of(1, -1, 0, 0, 0, 0));
      directed.push_back(pair_of(MaxI, 1, 1, MinI, 0, 0));
      directed.push_back(pair_of(-1, 0, 1, 0, 0, 0));
      directed.push_back(pair_of(1000, -3, -77, 0, 0, 0));
      directed.push_back(pair_of(0, 0, 1, 1, 1, 0));

      foreach (directed[i]) begin
         send_pair(directed[i], 1'b1);
      end

      // Random part; the final stretch runs back to back with no gaps.
      for (n = 0; n < RandomItems; n++) begin
         p.sx = $urandom();
         p.sy = $urandom();
         p.sz = $urandom();
         p.dx = random_offset(p.sx);
         p.dy = random_offset(p.sy);
         p.dz = random_offset(p.sz);
         p.typed = 1'b0;
         send_pair(p, n < RandomItems - QuietItems);
      end
      @(negedge clock);
      start <= 1'b0;

      while (pending_angles.size() != 0) begin
         @(posedge clock);
      end
      repeat (Latency + 10) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_direction_to_pitch_yaw: clean");
      end else begin
         $display("tb_direction_to_pitch_yaw: errors");
      end
      $finish;
   end

endmodule
